FILE: rtl/core/toy_cpu_instruction_execute_core_defines.svh
// ----------------------------------------------------------------------------
// Toy CPU execute core - assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef TOY_CPU_INSTRUCTION_EXECUTE_CORE_DEFINES_SVH
`define TOY_CPU_INSTRUCTION_EXECUTE_CORE_DEFINES_SVH

// check a condition at every clock edge
`define TCPU_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// check a consequence in the cycle after a trigger
`define TCPU_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/tcpu_pkg.sv
// ----------------------------------------------------------------------------
// Toy CPU execute core - package
// Sizes, opcodes, fault codes and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcpu_pkg;

    localparam int DATA_BYTES  = 4096;
    localparam int STACK_DEPTH = 256;
    localparam int FRAME_DEPTH = 16;

    localparam int PC_W  = 22;
    localparam int EA_W  = 26;
    localparam int DA_W  = $clog2(DATA_BYTES);
    localparam int VI_W  = $clog2(STACK_DEPTH);
    localparam int VSP_W = $clog2(STACK_DEPTH + 1);
    localparam int FI_W  = $clog2(FRAME_DEPTH);
    localparam int FP_W  = $clog2(FRAME_DEPTH + 1);
    localparam int FR_AW = FI_W + 3;

    typedef enum logic [4:0] {
        OP_HLT    = 5'd0,
        OP_JMP    = 5'd1,
        OP_CJMP   = 5'd2,
        OP_OJMP   = 5'd3,
        OP_CALL   = 5'd4,
        OP_RET    = 5'd5,
        OP_PUSH   = 5'd6,
        OP_POP    = 5'd7,
        OP_LOADB  = 5'd8,
        OP_LOADW  = 5'd9,
        OP_STOREB = 5'd10,
        OP_STOREW = 5'd11,
        OP_LOADI  = 5'd12,
        OP_NOP    = 5'd13,
        OP_IN     = 5'd14,
        OP_OUT    = 5'd15,
        OP_ADD    = 5'd16,
        OP_ADDI   = 5'd17,
        OP_SUB    = 5'd18,
        OP_SUBI   = 5'd19,
        OP_MUL    = 5'd20,
        OP_DIV    = 5'd21,
        OP_AND    = 5'd22,
        OP_OR     = 5'd23,
        OP_XOR    = 5'd24,
        OP_NOTB   = 5'd25,
        OP_SAL    = 5'd26,
        OP_SAR    = 5'd27,
        OP_EQU    = 5'd28,
        OP_LT     = 5'd29,
        OP_LTE    = 5'd30,
        OP_NOTC   = 5'd31
    } opcode_t;

    localparam logic [2:0] FLT_NONE     = 3'd0;
    localparam logic [2:0] FLT_DIV_ZERO = 3'd1;
    localparam logic [2:0] FLT_PUSH     = 3'd2;
    localparam logic [2:0] FLT_POP      = 3'd3;
    localparam logic [2:0] FLT_CALL     = 3'd4;
    localparam logic [2:0] FLT_RET      = 3'd5;
    localparam logic [2:0] FLT_RANGE    = 3'd6;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_OPND  = 9'b000000100,
        S_EXEC  = 9'b000001000,
        S_MEM   = 9'b000010000,
        S_DIV   = 9'b000100000,
        S_CALL  = 9'b001000000,
        S_RET   = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/toy_cpu_instruction_execute_core.sv
// ----------------------------------------------------------------------------
// Toy CPU execute core
// Executes one instruction word per request on eight 16-bit registers.
// ----------------------------------------------------------------------------
// Input channel instr_valid/instr_ready carries instruction and in_byte; the
// output channel result_valid/result_ready carries next_pc, halted,
// out_valid, out_byte and fault, one result per request, in order.
// Register file, data store, value stack and call frames sit in synchronous
// RAMs; each request reads its operands in the idle and operand states, then
// executes. Register, flag and jump operations finish in the execute state;
// pops, loads and stores pass through a memory state, DIV takes one quotient
// bit a cycle and CALL and RET move one saved register a cycle through the
// frame RAM. Requests are taken one at a time, the next one in the idle
// state after the result is registered.
// After reset the data store and registers are cleared, one byte a cycle,
// over all 4096 bytes; instr_ready stays low during that pass.
// The result waits in an output register; a new request is taken while it
// waits, and a stalled receiver holds the next result in the done state.
// Once HLT has executed every request returns the held program counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "toy_cpu_instruction_execute_core_defines.svh"

module toy_cpu_instruction_execute_core (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     instr_valid,
    output logic                          instr_ready,
    input  wire logic [31:0]              instruction,
    input  wire logic [7:0]               in_byte,
    output logic                          result_valid,
    input  wire logic                     result_ready,
    output logic [tcpu_pkg::PC_W-1:0]     next_pc,
    output logic                          halted,
    output logic                          out_valid,
    output logic [7:0]                    out_byte,
    output logic [2:0]                    fault
);

    localparam int PC_W  = tcpu_pkg::PC_W;
    localparam int EA_W  = tcpu_pkg::EA_W;
    localparam int DA_W  = tcpu_pkg::DA_W;
    localparam int VI_W  = tcpu_pkg::VI_W;
    localparam int VSP_W = tcpu_pkg::VSP_W;
    localparam int FI_W  = tcpu_pkg::FI_W;
    localparam int FP_W  = tcpu_pkg::FP_W;
    localparam int FR_AW = tcpu_pkg::FR_AW;

    // memories
    logic [15:0] rf_mem [8];
    logic [7:0]  dm_mem [tcpu_pkg::DATA_BYTES];
    logic [15:0] vs_mem [tcpu_pkg::STACK_DEPTH];
    logic [15:0] fr_mem [8 * tcpu_pkg::FRAME_DEPTH];
    logic [23:0] ft_mem [tcpu_pkg::FRAME_DEPTH];

    logic [2:0]       rf_ra0, rf_ra1, rf_wa;
    logic             rf_we;
    logic [15:0]      rf_wd, rf_q0_reg, rf_q1_reg;
    logic [DA_W-1:0]  dm_addr;
    logic             dm_we;
    logic [7:0]       dm_wd, dm_q_reg;
    logic [VI_W-1:0]  vs_addr;
    logic             vs_we;
    logic [15:0]      vs_wd, vs_q_reg;
    logic [FR_AW-1:0] fr_addr;
    logic             fr_we;
    logic [15:0]      fr_wd, fr_q_reg;
    logic [FI_W-1:0]  ft_addr;
    logic             ft_we, ft_re;
    logic [23:0]      ft_wd, ft_q_reg;

    // control state
    tcpu_pkg::state_t state_reg, state_next;
    logic [DA_W-1:0]  clr_reg, clr_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic [1:0]       step_reg, step_next;
    logic [PC_W-1:0]  pc_reg, pc_next;
    logic             halt_reg, halt_next;
    logic             ovf_reg, ovf_next;
    logic             cmpf_reg, cmpf_next;
    logic [VSP_W-1:0] vsp_reg, vsp_next;
    logic [FP_W-1:0]  fp_reg, fp_next;
    logic             res_valid_reg, res_valid_next;

    // payload
    logic [31:0]      ir_reg, ir_next;
    logic [7:0]       inb_reg, inb_next;
    logic [15:0]      a_reg, a_next, b_reg, b_next, rd_reg, rd_next;
    logic [DA_W-1:0]  ea_reg, ea_next;
    logic [7:0]       lo_reg, lo_next;
    logic [PC_W-1:0]  npc_reg, npc_next;
    logic [2:0]       flt_reg, flt_next;
    logic             ov_reg, ov_next;
    logic [7:0]       ob_reg, ob_next;
    logic [15:0]      div_q_reg, div_q_next, div_r_reg, div_r_next, div_d_reg, div_d_next;
    logic             div_neg_reg, div_neg_next;
    logic [PC_W-1:0]  res_pc_reg, res_pc_next;
    logic             res_halt_reg, res_halt_next;
    logic             res_ov_reg, res_ov_next;
    logic [7:0]       res_ob_reg, res_ob_next;
    logic [2:0]       res_flt_reg, res_flt_next;

    // execute datapath
    tcpu_pkg::opcode_t op;
    logic [2:0]       ra_i;
    logic [15:0]      imm, rd_w, r7_w, add_x, add_y, sal_w, sar_w, a_mag, b_mag, div_res;
    logic [16:0]      sum_w;
    logic             is_sub, is_imm;
    logic [31:0]      prod_w;
    logic [EA_W-1:0]  ea_b, ea_w;
    logic             ok_b, ok_w;
    logic [PC_W-1:0]  target, npc_inc;
    logic [FI_W-1:0]  fp_idx;
    logic [2:0]       cnt_m1;
    logic [16:0]      div_sh;
    logic [17:0]      div_diff;

    assign op      = tcpu_pkg::opcode_t'(ir_reg[31:27]);
    assign ra_i    = ir_reg[26:24];
    assign imm     = ir_reg[15:0];
    assign rd_w    = rf_q0_reg;
    assign r7_w    = rf_q1_reg;
    assign target  = ir_reg[23:2];
    assign npc_inc = pc_reg + PC_W'(1);
    assign fp_idx  = fp_reg[FI_W-1:0];
    assign cnt_m1  = 3'(cnt_reg - 5'd1);

    assign is_imm = (op == tcpu_pkg::OP_ADDI) || (op == tcpu_pkg::OP_SUBI);
    assign is_sub = (op == tcpu_pkg::OP_SUB) || (op == tcpu_pkg::OP_SUBI);
    assign add_x  = is_imm ? rd_w : a_reg;
    assign add_y  = is_imm ? imm : b_reg;
    assign sum_w  = is_sub ? ({add_x[15], add_x} - {add_y[15], add_y})
                           : ({add_x[15], add_x} + {add_y[15], add_y});
    assign prod_w = 32'($signed(a_reg) * $signed(b_reg));
    assign sal_w  = (b_reg >= 16'd16) ? 16'd0 : (a_reg << b_reg[3:0]);
    assign sar_w  = 16'($signed(a_reg) >>> ((b_reg > 16'd15) ? 4'd15 : b_reg[3:0]));
    assign a_mag  = a_reg[15] ? (16'd0 - a_reg) : a_reg;
    assign b_mag  = b_reg[15] ? (16'd0 - b_reg) : b_reg;

    assign ea_b = {2'b00, ir_reg[23:0]} + {{10{r7_w[15]}}, r7_w};
    assign ea_w = {2'b00, ir_reg[23:0]} + {{9{r7_w[15]}}, r7_w, 1'b0};
    assign ok_b = !ea_b[EA_W-1] && (ea_b < EA_W'(tcpu_pkg::DATA_BYTES));
    assign ok_w = !ea_w[EA_W-1] && (ea_w < EA_W'(tcpu_pkg::DATA_BYTES - 1));

    assign div_sh   = {div_r_reg, div_q_reg[15]};
    assign div_diff = {1'b0, div_sh} - {2'b00, div_d_reg};
    assign div_res  = div_neg_reg ? (16'd0 - div_q_reg) : div_q_reg;

    assign instr_ready  = (state_reg == tcpu_pkg::S_IDLE);
    assign result_valid = res_valid_reg;
    assign next_pc      = res_pc_reg;
    assign halted       = res_halt_reg;
    assign out_valid    = res_ov_reg;
    assign out_byte     = res_ob_reg;
    assign fault        = res_flt_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cnt_next       = cnt_reg;
        step_next      = step_reg;
        pc_next        = pc_reg;
        halt_next      = halt_reg;
        ovf_next       = ovf_reg;
        cmpf_next      = cmpf_reg;
        vsp_next       = vsp_reg;
        fp_next        = fp_reg;
        res_valid_next = res_valid_reg;
        ir_next        = ir_reg;
        inb_next       = inb_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        rd_next        = rd_reg;
        ea_next        = ea_reg;
        lo_next        = lo_reg;
        npc_next       = npc_reg;
        flt_next       = flt_reg;
        ov_next        = ov_reg;
        ob_next        = ob_reg;
        div_q_next     = div_q_reg;
        div_r_next     = div_r_reg;
        div_d_next     = div_d_reg;
        div_neg_next   = div_neg_reg;
        res_pc_next    = res_pc_reg;
        res_halt_next  = res_halt_reg;
        res_ov_next    = res_ov_reg;
        res_ob_next    = res_ob_reg;
        res_flt_next   = res_flt_reg;

        rf_ra0  = ra_i;
        rf_ra1  = 3'd7;
        rf_we   = 1'b0;
        rf_wa   = ra_i;
        rf_wd   = 16'd0;
        dm_addr = ea_reg;
        dm_we   = 1'b0;
        dm_wd   = 8'd0;
        vs_addr = vsp_reg[VI_W-1:0];
        vs_we   = 1'b0;
        vs_wd   = rd_w;
        fr_addr = {fp_idx, cnt_reg[2:0]};
        fr_we   = 1'b0;
        fr_wd   = rf_q0_reg;
        ft_addr = fp_idx;
        ft_we   = 1'b0;
        ft_re   = 1'b0;
        ft_wd   = {cmpf_reg, ovf_reg, npc_inc};

        if (res_valid_reg && result_ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            tcpu_pkg::S_CLEAR:
            begin
                dm_addr = clr_reg;
                dm_we   = 1'b1;
                rf_wa   = clr_reg[2:0];
                rf_we   = (clr_reg < DA_W'(8));
                clr_next = clr_reg + DA_W'(1);
                if (clr_reg == DA_W'(tcpu_pkg::DATA_BYTES - 1))
                begin
                    state_next = tcpu_pkg::S_IDLE;
                end
            end

            tcpu_pkg::S_IDLE:
            begin
                rf_ra0 = instruction[22:20];
                rf_ra1 = instruction[18:16];
                if (instr_valid)
                begin
                    ir_next  = instruction;
                    inb_next = in_byte;
                    flt_next = tcpu_pkg::FLT_NONE;
                    ov_next  = 1'b0;
                    ob_next  = 8'd0;
                    npc_next = pc_reg;
                    state_next = halt_reg ? tcpu_pkg::S_DONE : tcpu_pkg::S_OPND;
                end
            end

            tcpu_pkg::S_OPND:
            begin
                a_next     = rf_q0_reg;
                b_next     = rf_q1_reg;
                state_next = tcpu_pkg::S_EXEC;
            end

            tcpu_pkg::S_EXEC:
            begin
                rd_next    = rd_w;
                npc_next   = npc_inc;
                cnt_next   = 5'd0;
                step_next  = 2'd0;
                state_next = tcpu_pkg::S_DONE;
                case (op)
                    tcpu_pkg::OP_HLT:  halt_next = 1'b1;
                    tcpu_pkg::OP_JMP:  npc_next = target;
                    tcpu_pkg::OP_CJMP: if (cmpf_reg) npc_next = target;
                    tcpu_pkg::OP_OJMP: if (ovf_reg) npc_next = target;
                    tcpu_pkg::OP_CALL:
                    begin
                        if (fp_reg >= FP_W'(tcpu_pkg::FRAME_DEPTH))
                        begin
                            flt_next = tcpu_pkg::FLT_CALL;
                        end
                        else
                        begin
                            ft_we      = 1'b1;
                            state_next = tcpu_pkg::S_CALL;
                        end
                    end
                    tcpu_pkg::OP_RET:
                    begin
                        if ((fp_reg == FP_W'(0)) || (fp_reg > FP_W'(tcpu_pkg::FRAME_DEPTH)))
                        begin
                            flt_next = tcpu_pkg::FLT_RET;
                        end
                        else
                        begin
                            fp_next    = fp_reg - FP_W'(1);
                            state_next = tcpu_pkg::S_RET;
                        end
                    end
                    tcpu_pkg::OP_PUSH:
                    begin
                        if (vsp_reg >= VSP_W'(tcpu_pkg::STACK_DEPTH))
                        begin
                            flt_next = tcpu_pkg::FLT_PUSH;
                        end
                        else
                        begin
                            vs_we    = 1'b1;
                            vsp_next = vsp_reg + VSP_W'(1);
                        end
                    end
                    tcpu_pkg::OP_POP:
                    begin
                        if ((vsp_reg == VSP_W'(0)) || (vsp_reg > VSP_W'(tcpu_pkg::STACK_DEPTH)))
                        begin
                            flt_next = tcpu_pkg::FLT_POP;
                        end
                        else
                        begin
                            vsp_next   = vsp_reg - VSP_W'(1);
                            vs_addr    = VI_W'(vsp_reg - VSP_W'(1));
                            state_next = tcpu_pkg::S_MEM;
                        end
                    end
                    tcpu_pkg::OP_LOADB, tcpu_pkg::OP_STOREB:
                    begin
                        ea_next = ea_b[DA_W-1:0];
                        if (ok_b) state_next = tcpu_pkg::S_MEM;
                        else flt_next = tcpu_pkg::FLT_RANGE;
                    end
                    tcpu_pkg::OP_LOADW, tcpu_pkg::OP_STOREW:
                    begin
                        ea_next = ea_w[DA_W-1:0];
                        if (ok_w) state_next = tcpu_pkg::S_MEM;
                        else flt_next = tcpu_pkg::FLT_RANGE;
                    end
                    tcpu_pkg::OP_LOADI:
                    begin
                        rf_we = 1'b1;
                        rf_wd = imm;
                    end
                    tcpu_pkg::OP_NOP:  ;
                    tcpu_pkg::OP_IN:
                    begin
                        rf_we = 1'b1;
                        rf_wd = {rd_w[15:8], inb_reg};
                    end
                    tcpu_pkg::OP_OUT:
                    begin
                        ov_next = 1'b1;
                        ob_next = rd_w[7:0];
                    end
                    tcpu_pkg::OP_ADD, tcpu_pkg::OP_ADDI, tcpu_pkg::OP_SUB, tcpu_pkg::OP_SUBI:
                    begin
                        rf_we    = 1'b1;
                        rf_wd    = sum_w[15:0];
                        ovf_next = sum_w[16] ^ sum_w[15];
                    end
                    tcpu_pkg::OP_MUL:
                    begin
                        rf_we    = 1'b1;
                        rf_wd    = prod_w[15:0];
                        ovf_next = !((prod_w[31:15] == 17'h1FFFF) || (prod_w[31:15] == 17'h0));
                    end
                    tcpu_pkg::OP_DIV:
                    begin
                        if (b_reg == 16'd0)
                        begin
                            flt_next = tcpu_pkg::FLT_DIV_ZERO;
                        end
                        else
                        begin
                            div_q_next   = a_mag;
                            div_r_next   = 16'd0;
                            div_d_next   = b_mag;
                            div_neg_next = a_reg[15] ^ b_reg[15];
                            state_next   = tcpu_pkg::S_DIV;
                        end
                    end
                    tcpu_pkg::OP_AND:
                    begin
                        rf_we = 1'b1;
                        rf_wd = a_reg & b_reg;
                    end
                    tcpu_pkg::OP_OR:
                    begin
                        rf_we = 1'b1;
                        rf_wd = a_reg | b_reg;
                    end
                    tcpu_pkg::OP_XOR:
                    begin
                        rf_we = 1'b1;
                        rf_wd = a_reg ^ b_reg;
                    end
                    tcpu_pkg::OP_NOTB:
                    begin
                        rf_we = 1'b1;
                        rf_wd = ~a_reg;
                    end
                    tcpu_pkg::OP_SAL:
                    begin
                        rf_we = 1'b1;
                        rf_wd = sal_w;
                    end
                    tcpu_pkg::OP_SAR:
                    begin
                        rf_we = 1'b1;
                        rf_wd = sar_w;
                    end
                    tcpu_pkg::OP_EQU:  cmpf_next = (rd_w == a_reg);
                    tcpu_pkg::OP_LT:   cmpf_next = ($signed(rd_w) < $signed(a_reg));
                    tcpu_pkg::OP_LTE:  cmpf_next = ($signed(rd_w) <= $signed(a_reg));
                    default:           cmpf_next = !cmpf_reg;
                endcase
            end

            tcpu_pkg::S_MEM:
            begin
                step_next = step_reg + 2'd1;
                case (op)
                    tcpu_pkg::OP_POP:
                    begin
                        rf_we      = 1'b1;
                        rf_wd      = vs_q_reg;
                        state_next = tcpu_pkg::S_DONE;
                    end
                    tcpu_pkg::OP_LOADB:
                    begin
                        if (step_reg == 2'd1)
                        begin
                            rf_we      = 1'b1;
                            rf_wd      = {8'd0, dm_q_reg};
                            state_next = tcpu_pkg::S_DONE;
                        end
                    end
                    tcpu_pkg::OP_LOADW:
                    begin
                        if (step_reg == 2'd1)
                        begin
                            dm_addr = ea_reg + DA_W'(1);
                            lo_next = dm_q_reg;
                        end
                        else if (step_reg == 2'd2)
                        begin
                            rf_we      = 1'b1;
                            rf_wd      = {dm_q_reg, lo_reg};
                            state_next = tcpu_pkg::S_DONE;
                        end
                    end
                    tcpu_pkg::OP_STOREB:
                    begin
                        dm_we      = 1'b1;
                        dm_wd      = rd_reg[7:0];
                        state_next = tcpu_pkg::S_DONE;
                    end
                    tcpu_pkg::OP_STOREW:
                    begin
                        dm_we = 1'b1;
                        if (step_reg == 2'd0)
                        begin
                            dm_wd = rd_reg[7:0];
                        end
                        else
                        begin
                            dm_addr    = ea_reg + DA_W'(1);
                            dm_wd      = rd_reg[15:8];
                            state_next = tcpu_pkg::S_DONE;
                        end
                    end
                    default: state_next = tcpu_pkg::S_DONE;
                endcase
            end

            tcpu_pkg::S_DIV:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd16)
                begin
                    rf_we      = 1'b1;
                    rf_wd      = div_res;
                    state_next = tcpu_pkg::S_DONE;
                end
                else if (!div_diff[17])
                begin
                    div_r_next = div_diff[15:0];
                    div_q_next = {div_q_reg[14:0], 1'b1};
                end
                else
                begin
                    div_r_next = div_sh[15:0];
                    div_q_next = {div_q_reg[14:0], 1'b0};
                end
            end

            tcpu_pkg::S_CALL:
            begin
                rf_ra0   = cnt_reg[2:0];
                fr_addr  = {fp_idx, cnt_m1};
                fr_we    = (cnt_reg != 5'd0);
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd8)
                begin
                    fp_next    = fp_reg + FP_W'(1);
                    npc_next   = target;
                    state_next = tcpu_pkg::S_DONE;
                end
            end

            tcpu_pkg::S_RET:
            begin
                ft_re    = (cnt_reg == 5'd0);
                rf_wa    = cnt_m1;
                rf_wd    = fr_q_reg;
                rf_we    = (cnt_reg != 5'd0);
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd8)
                begin
                    npc_next   = ft_q_reg[PC_W-1:0];
                    ovf_next   = ft_q_reg[22];
                    cmpf_next  = ft_q_reg[23];
                    state_next = tcpu_pkg::S_DONE;
                end
            end

            tcpu_pkg::S_DONE:
            begin
                if (!res_valid_reg || result_ready)
                begin
                    pc_next        = npc_reg;
                    res_valid_next = 1'b1;
                    res_pc_next    = npc_reg;
                    res_halt_next  = halt_reg;
                    res_ov_next    = ov_reg;
                    res_ob_next    = ob_reg;
                    res_flt_next   = flt_reg;
                    state_next     = tcpu_pkg::S_IDLE;
                end
            end

            default: state_next = tcpu_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcpu_pkg::S_CLEAR;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            step_reg      <= '0;
            pc_reg        <= '0;
            halt_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            cmpf_reg      <= 1'b0;
            vsp_reg       <= '0;
            fp_reg        <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
            step_reg      <= step_next;
            pc_reg        <= pc_next;
            halt_reg      <= halt_next;
            ovf_reg       <= ovf_next;
            cmpf_reg      <= cmpf_next;
            vsp_reg       <= vsp_next;
            fp_reg        <= fp_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ir_reg       <= ir_next;
        inb_reg      <= inb_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        rd_reg       <= rd_next;
        ea_reg       <= ea_next;
        lo_reg       <= lo_next;
        npc_reg      <= npc_next;
        flt_reg      <= flt_next;
        ov_reg       <= ov_next;
        ob_reg       <= ob_next;
        div_q_reg    <= div_q_next;
        div_r_reg    <= div_r_next;
        div_d_reg    <= div_d_next;
        div_neg_reg  <= div_neg_next;
        res_pc_reg   <= res_pc_next;
        res_halt_reg <= res_halt_next;
        res_ov_reg   <= res_ov_next;
        res_ob_reg   <= res_ob_next;
        res_flt_reg  <= res_flt_next;
    end

    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_mem[rf_wa] <= rf_wd;
        end
        rf_q0_reg <= rf_mem[rf_ra0];
        rf_q1_reg <= rf_mem[rf_ra1];
    end

    always_ff @(posedge clk)
    begin
        if (dm_we)
        begin
            dm_mem[dm_addr] <= dm_wd;
        end
        dm_q_reg <= dm_mem[dm_addr];
    end

    always_ff @(posedge clk)
    begin
        if (vs_we)
        begin
            vs_mem[vs_addr] <= vs_wd;
        end
        vs_q_reg <= vs_mem[vs_addr];
    end

    always_ff @(posedge clk)
    begin
        if (fr_we)
        begin
            fr_mem[fr_addr] <= fr_wd;
        end
        fr_q_reg <= fr_mem[fr_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ft_we)
        begin
            ft_mem[ft_addr] <= ft_wd;
        end
        if (ft_re)
        begin
            ft_q_reg <= ft_mem[ft_addr];
        end
    end

    `TCPU_ASSERT_ALWAYS(a_state_onehot, $onehot(state_reg), "sequencer state not one-hot")
    `TCPU_ASSERT_ALWAYS(a_vsp_range, vsp_reg <= VSP_W'(tcpu_pkg::STACK_DEPTH),
        "value stack pointer beyond depth")
    `TCPU_ASSERT_ALWAYS(a_fp_range, fp_reg <= FP_W'(tcpu_pkg::FRAME_DEPTH),
        "frame pointer beyond depth")
    `TCPU_ASSERT_NEXT(a_halted_hold, instr_valid && instr_ready && halt_reg,
        $stable(pc_reg) && (state_reg == tcpu_pkg::S_DONE), "halted request moved state")
    `TCPU_ASSERT_NEXT(a_result_load, (state_reg == tcpu_pkg::S_DONE) &&
        (!res_valid_reg || result_ready), result_valid && (pc_reg == next_pc),
        "result not presented after completion")

endmodule

`default_nettype wire
